/* design/tcf_pkg.sv */
// Shared types, constants and the arctangent table for the tilt filter.
// Used by the controller, the datapath and the top level.
`default_nettype none
package tcf_pkg;
   localparam int CordicSteps = 16;
   localparam int StepWidth = $clog2(CordicSteps + 1);
   localparam logic signed [31:0] Deg90 = 32'sd5898240;

   typedef enum logic [2:0] {
      ST_IDLE, ST_SQRT, ST_ROLL, ST_PITCH, ST_FUSE, ST_DONE
   } state_type;

   typedef enum logic [0:0] {
      REG_BLEND_WEIGHT = 1'b0,
      REG_TICK_SECONDS = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic load;
      logic sqrt_init;
      logic sqrt_step;
      logic cordic_init;
      logic cordic_sel;
      logic cordic_step;
      logic roll_save;
      logic fuse_step;
   } cmd_type;

   typedef struct packed {
      logic sqrt_done;
      logic cordic_done;
      logic fuse_done;
   } sts_type;

   function automatic logic signed [31:0] atan_entry(input logic [4:0] i);
      logic signed [31:0] v;
      v = 32'sd0;
      case (i)
         5'd0: v = 32'sd2949120;  5'd1: v = 32'sd1740967;
         5'd2: v = 32'sd919879;   5'd3: v = 32'sd466945;
         5'd4: v = 32'sd234379;   5'd5: v = 32'sd117304;
         5'd6: v = 32'sd58666;    5'd7: v = 32'sd29335;
         5'd8: v = 32'sd14668;    5'd9: v = 32'sd7334;
         5'd10: v = 32'sd3667;    5'd11: v = 32'sd1833;
         5'd12: v = 32'sd917;     5'd13: v = 32'sd458;
         5'd14: v = 32'sd229;     5'd15: v = 32'sd115;
         5'd16: v = 32'sd57;      5'd17: v = 32'sd29;
         5'd18: v = 32'sd14;      5'd19: v = 32'sd7;
         5'd20: v = 32'sd4;       5'd21: v = 32'sd2;
         5'd22: v = 32'sd1;       default: v = 32'sd0;
      endcase
      return v;
   endfunction
endpackage
`default_nettype wire

/* design/tcf_ctrl.sv */
// Sequencer for the tilt filter: steps square root, two CORDIC passes, fuse.
// Depends on tcf_pkg.
`default_nettype none
module tcf_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_fire,
   input  wire logic              rsp_free,
   input  wire tcf_pkg::sts_type  sts,
   output tcf_pkg::cmd_type       cmd,
   output logic                   busy,
   output logic                   rsp_load
);
   tcf_pkg::state_type state_ff, state_in;

   // hold state
   always_ff @(posedge clock) begin
      if (reset) state_ff <= tcf_pkg::ST_IDLE;
      else state_ff <= state_in;
   end

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd = '0;
      rsp_load = 1'b0;
      busy = (state_ff != tcf_pkg::ST_IDLE);
      unique case (state_ff)
         tcf_pkg::ST_IDLE: begin
            if (req_fire) begin
               cmd.load = 1'b1;
               state_in = tcf_pkg::ST_SQRT;
            end
         end
         tcf_pkg::ST_SQRT: begin
            if (sts.sqrt_done) begin
               cmd.cordic_init = 1'b1;
               state_in = tcf_pkg::ST_ROLL;
            end else cmd.sqrt_step = 1'b1;
         end
         tcf_pkg::ST_ROLL: begin
            if (sts.cordic_done) begin
               cmd.roll_save = 1'b1;
               cmd.cordic_init = 1'b1;
               cmd.cordic_sel = 1'b1;
               state_in = tcf_pkg::ST_PITCH;
            end else cmd.cordic_step = 1'b1;
         end
         tcf_pkg::ST_PITCH: begin
            if (sts.cordic_done) state_in = tcf_pkg::ST_FUSE;
            else cmd.cordic_step = 1'b1;
         end
         tcf_pkg::ST_FUSE: begin
            if (sts.fuse_done) state_in = tcf_pkg::ST_DONE;
            else cmd.fuse_step = 1'b1;
         end
         tcf_pkg::ST_DONE: begin
            if (rsp_free) begin
               rsp_load = 1'b1;
               state_in = tcf_pkg::ST_IDLE;
            end
         end
         default: state_in = tcf_pkg::ST_IDLE;
      endcase
      cmd.sqrt_init = cmd.load;
   end

   assert property (@(posedge clock) disable iff (reset)
      req_fire |-> state_ff == tcf_pkg::ST_IDLE)
      else $error("word accepted while busy");
   assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> state_ff == tcf_pkg::ST_IDLE)
      else $error("result load left sequencer busy");
   assert property (@(posedge clock) disable iff (reset)
      cmd.roll_save |-> state_ff == tcf_pkg::ST_ROLL)
      else $error("roll saved outside roll pass");
endmodule
`default_nettype wire

/* design/tcf_datapath.sv */
// Datapath: held samples, bitwise square root, shared CORDIC, blend and accumulators.
// Depends on tcf_pkg; driven by tcf_ctrl commands.
`default_nettype none
module tcf_datapath (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire tcf_pkg::cmd_type   cmd,
   output tcf_pkg::sts_type        sts,
   input  wire logic               accel_fresh,
   input  wire logic signed [15:0] accel_x,
   input  wire logic signed [15:0] accel_y,
   input  wire logic signed [15:0] accel_z,
   input  wire logic               gyro_fresh,
   input  wire logic signed [15:0] rate_x,
   input  wire logic signed [15:0] rate_y,
   input  wire logic [15:0]        blend_weight,
   input  wire logic [23:0]        tick_seconds,
   output logic signed [17:0]      roll_angle,
   output logic signed [17:0]      pitch_angle
);
   logic signed [15:0] ax_ff, ay_ff, az_ff, rx_ff, ry_ff;
   logic signed [31:0] roll_ff, pitch_ff;

   // latch fresh samples
   always_ff @(posedge clock) begin
      if (reset) begin
         ax_ff <= '0; ay_ff <= '0; az_ff <= '0; rx_ff <= '0; ry_ff <= '0;
      end else if (cmd.load) begin
         if (accel_fresh) begin
            ax_ff <= accel_x; ay_ff <= accel_y; az_ff <= accel_z;
         end
         if (gyro_fresh) begin
            rx_ff <= rate_x; ry_ff <= rate_y;
         end
      end
   end

   // square root: radicand (ay^2+az^2)<<16 fits 48 bits, root 24 bits, 2 bits/step
   logic [47:0] rem_ff, rem_in;
   logic [23:0] root_ff, root_in;
   logic [47:0] rad_ff;
   logic [4:0]  sq_cnt_ff;
   logic [31:0] sq_sum;
   logic [49:0] trial;
   logic [49:0] rem_sh;
   logic sq_first_ff;
   assign sq_sum = 32'($signed(ay_ff) * $signed(ay_ff)) + 32'($signed(az_ff) * $signed(az_ff));
   always_comb begin
      rem_sh = {rem_ff, rad_ff[47:46]};
      trial = {24'd0, root_ff, 2'b01};
      if (rem_sh >= trial) begin
         rem_in = 48'(rem_sh - trial);
         root_in = {root_ff[22:0], 1'b1};
      end else begin
         rem_in = rem_sh[47:0];
         root_in = {root_ff[22:0], 1'b0};
      end
   end
   always_ff @(posedge clock) begin
      if (reset) sq_first_ff <= 1'b0;
      else sq_first_ff <= cmd.sqrt_init;
   end
   always_ff @(posedge clock) begin
      if (reset) sq_cnt_ff <= '0;
      else if (cmd.sqrt_init) sq_cnt_ff <= 5'd24;
      else if (cmd.sqrt_step && !sq_first_ff) sq_cnt_ff <= sq_cnt_ff - 5'd1;
   end
   always_ff @(posedge clock) begin
      if (cmd.sqrt_init) begin
         rem_ff <= '0; root_ff <= '0;
      end else if (sq_first_ff) begin
         // radicand loads on the cycle after the sample latch
         rad_ff <= {sq_sum, 16'd0};
      end else if (cmd.sqrt_step) begin
         rem_ff <= rem_in; root_ff <= root_in; rad_ff <= {rad_ff[45:0], 2'b00};
      end
   end
   assign sts.sqrt_done = (sq_cnt_ff == 5'd0) && !sq_first_ff;

   // CORDIC vectoring, one step per cycle; 42-bit x/y hold growth of operands of at most 25 bits
   logic signed [41:0] cx_ff, cy_ff, cx_in, cy_in, x0, y0, xs, ys;
   logic signed [31:0] cz_ff, cz_in, z0, roll_acc_ff;
   logic [tcf_pkg::StepWidth-1:0] ci_ff;
   logic c_zero_ff;
   always_comb begin
      if (cmd.cordic_sel) begin
         x0 = 42'($signed({1'b0, root_ff}));
         y0 = -(42'(ax_ff) <<< 8);
      end else begin
         x0 = 42'(az_ff) <<< 8;
         y0 = 42'(ay_ff) <<< 8;
      end
      z0 = '0;
      if (x0 < 0) begin
         if (y0 >= 0) begin
            z0 = tcf_pkg::Deg90; cx_in = y0; cy_in = -x0;
         end else begin
            z0 = -tcf_pkg::Deg90; cx_in = -y0; cy_in = x0;
         end
      end else begin
         cx_in = x0; cy_in = y0;
      end
      xs = cx_ff >>> ci_ff;
      ys = cy_ff >>> ci_ff;
      cz_in = z0;
   end
   always_ff @(posedge clock) begin
      if (reset) ci_ff <= '0;
      else if (cmd.cordic_init) ci_ff <= '0;
      else if (cmd.cordic_step) ci_ff <= ci_ff + 1'b1;
   end
   always_ff @(posedge clock) begin
      if (cmd.cordic_init) begin
         cx_ff <= cx_in; cy_ff <= cy_in; cz_ff <= cz_in;
         c_zero_ff <= (x0 == 0) && (y0 == 0);
      end else if (cmd.cordic_step) begin
         if (cy_ff < 0) begin
            cx_ff <= cx_ff - ys; cy_ff <= cy_ff + xs;
            cz_ff <= cz_ff - tcf_pkg::atan_entry(5'(ci_ff));
         end else begin
            cx_ff <= cx_ff + ys; cy_ff <= cy_ff - xs;
            cz_ff <= cz_ff + tcf_pkg::atan_entry(5'(ci_ff));
         end
      end
      if (cmd.roll_save) roll_acc_ff <= c_zero_ff ? 32'sd0 : cz_ff;
   end
   assign sts.cordic_done = (ci_ff == tcf_pkg::StepWidth'(tcf_pkg::CordicSteps));
   logic signed [31:0] pitch_acc;
   assign pitch_acc = c_zero_ff ? 32'sd0 : cz_ff;

   // fuse: phase 0 gyro product, 1 prediction, 2 weight*pred and (1-weight)*acc, 3 sum; roll then pitch
   logic [2:0] fph_ff;
   logic fph_done_ff;
   logic signed [40:0] gterm_ff;
   logic signed [33:0] pred_ff;
   logic signed [50:0] p1_ff, p2_ff;
   logic signed [51:0] sum;
   logic signed [31:0] fused;
   logic signed [15:0] rsel;
   logic signed [31:0] prev, accsel;
   assign rsel = fph_ff[2] ? ry_ff : rx_ff;
   assign prev = fph_ff[2] ? pitch_ff : roll_ff;
   assign accsel = fph_ff[2] ? pitch_acc : roll_acc_ff;
   always_comb begin
      sum = 52'(p1_ff) + 52'(p2_ff) + 52'sd32768;
      sum = sum >>> 16;
      if (sum > 52'sh7FFFFFFF) fused = 32'sh7FFFFFFF;
      else if (sum < -52'sh80000000) fused = -32'sh80000000;
      else fused = 32'(sum);
   end
   always_ff @(posedge clock) begin
      if (reset) fph_ff <= '0;
      else if (cmd.load) fph_ff <= '0;
      else if (cmd.fuse_step) fph_ff <= fph_ff + 3'd1;
   end
   always_ff @(posedge clock) begin
      if (reset || cmd.load) fph_done_ff <= 1'b0;
      else if (cmd.fuse_step && fph_ff == 3'd7) fph_done_ff <= 1'b1;
   end
   assign sts.fuse_done = (fph_ff == 3'd0) && sq_cnt_ff == 5'd0 && !sq_first_ff
      && sts.cordic_done && fph_done_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         roll_ff <= '0; pitch_ff <= '0;
      end else if (cmd.fuse_step) begin
         case (fph_ff[1:0])
            2'd0: gterm_ff <= 41'(rsel) * $signed({1'b0, tick_seconds});
            2'd1: pred_ff <= 34'(prev) + 34'(gterm_ff >>> 12);
            2'd2: begin
               p1_ff <= 51'($signed({1'b0, blend_weight})) * 51'(pred_ff);
               p2_ff <= 51'($signed(18'd65536 - {2'b0, blend_weight})) * 51'(accsel);
            end
            default: begin
               if (fph_ff[2]) pitch_ff <= fused;
               else roll_ff <= fused;
            end
         endcase
      end
   end

   function automatic logic signed [17:0] to_out(input logic signed [31:0] a);
      logic signed [23:0] s;
      s = 24'(a >>> 8);
      if (s > 24'sd131071) return 18'sd131071;
      else if (s < -24'sd131072) return -18'sd131072;
      else return 18'(s);
   endfunction
   assign roll_angle = to_out(roll_ff);
   assign pitch_angle = to_out(pitch_ff);

   assert property (@(posedge clock) disable iff (reset)
      cmd.cordic_step |-> !sts.cordic_done)
      else $error("CORDIC stepped past its last step");
   assert property (@(posedge clock) disable iff (reset)
      cmd.sqrt_step |-> sq_cnt_ff != 5'd0)
      else $error("square root stepped past its last digit");
endmodule
`default_nettype wire

/* design/tilt_complementary_filter_unit.sv */
// Tilt complementary filter: fuses accelerometer tilt with integrated gyro rate
// into roll and pitch. After a word is accepted the unit does one radicand load
// and 24 square-root digit steps, two 16-step CORDIC vectoring passes on one
// shared unit, and the blend steps for roll then pitch, then loads the result
// register. One word is worked on at a time; the next word can enter once the
// result is loaded, and the result register lets it enter while a result waits.
`default_nettype none
module tilt_complementary_filter_unit (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic               req_accel_fresh,
   input  wire logic signed [15:0] req_accel_x,
   input  wire logic signed [15:0] req_accel_y,
   input  wire logic signed [15:0] req_accel_z,
   input  wire logic               req_gyro_fresh,
   input  wire logic signed [15:0] req_rate_x,
   input  wire logic signed [15:0] req_rate_y,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic signed [17:0]      rsp_roll_angle,
   output logic signed [17:0]      rsp_pitch_angle,
   input  wire logic               csr_write,
   input  wire logic [0:0]         csr_index,
   input  wire logic [23:0]        csr_data
);
   logic [15:0] weight_ff;
   logic [23:0] tick_ff;
   logic rsp_valid_ff;
   logic signed [17:0] roll_ff, pitch_ff, roll_w, pitch_w;
   tcf_pkg::cmd_type cmd;
   tcf_pkg::sts_type sts;
   logic busy, rsp_load, req_fire;

   assign req_ready = !busy;
   assign req_fire = req_valid && req_ready;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         weight_ff <= 16'd64225;
         tick_ff <= 24'd167772;
      end else if (csr_write) begin
         if (csr_index == tcf_pkg::REG_BLEND_WEIGHT) weight_ff <= csr_data[15:0];
         else tick_ff <= csr_data;
      end
   end

   tcf_ctrl u_ctrl (
      .clock, .reset, .req_fire,
      .rsp_free(!rsp_valid_ff || rsp_ready),
      .sts, .cmd, .busy, .rsp_load
   );

   tcf_datapath u_dp (
      .clock, .reset, .cmd, .sts,
      .accel_fresh(req_accel_fresh), .accel_x(req_accel_x),
      .accel_y(req_accel_y), .accel_z(req_accel_z),
      .gyro_fresh(req_gyro_fresh), .rate_x(req_rate_x), .rate_y(req_rate_y),
      .blend_weight(weight_ff), .tick_seconds(tick_ff),
      .roll_angle(roll_w), .pitch_angle(pitch_w)
   );

   // output word register
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (rsp_load) rsp_valid_ff <= 1'b1;
      else if (rsp_ready) rsp_valid_ff <= 1'b0;
   end
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         roll_ff <= roll_w; pitch_ff <= pitch_w;
      end
   end
   assign rsp_valid = rsp_valid_ff;
   assign rsp_roll_angle = roll_ff;
   assign rsp_pitch_angle = pitch_ff;

   assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> !rsp_valid_ff || rsp_ready)
      else $error("result word overwritten");
endmodule
`default_nettype wire

/* tb/sv/tb_top.sv */
// Testbench for the tilt complementary filter: directed table, then random sample ticks.
// Depends on tcf_pkg and tilt_complementary_filter_unit; predicts each result word itself.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
   localparam int  GapMax = 19;
   localparam int  SettleCycles = 120;
   localparam longint CycleLimit = 900000;
   localparam longint Deg90Q16 = 5898240;

   typedef struct {
      logic              accel_fresh;
      logic signed [15:0] accel_x, accel_y, accel_z;
      logic              gyro_fresh;
      logic signed [15:0] rate_x, rate_y;
      logic              typed;
      logic signed [17:0] roll, pitch;
   } tick_row_type;

   typedef struct {
      logic signed [17:0] roll, pitch;
   } angle_word_type;

   // tb-side arctangent table, Q16.16 degrees
   longint atan_table [24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
                                14668, 7334, 3667, 1833, 917, 458, 229, 115,
                                57, 29, 14, 7, 4, 2, 1, 0};

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_accel_fresh = 1'b0;
   logic signed [15:0] req_accel_x = '0, req_accel_y = '0, req_accel_z = '0;
   logic req_gyro_fresh = 1'b0;
   logic signed [15:0] req_rate_x = '0, req_rate_y = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [17:0] rsp_roll_angle, rsp_pitch_angle;
   logic csr_write = 1'b0;
   logic [0:0] csr_index = '0;
   logic [23:0] csr_data = '0;

   // typed expectation travels with the word
   logic cur_typed = 1'b0;
   logic signed [17:0] cur_roll = '0, cur_pitch = '0;

   // predictor state and its copy of the registers
   longint unsigned weight_q16 = 64225;
   longint unsigned dt_q24 = 167772;
   logic signed [15:0] hold_ax = '0, hold_ay = '0, hold_az = '0;
   logic signed [15:0] hold_rx = '0, hold_ry = '0;
   logic signed [31:0] roll_q16 = '0, pitch_q16 = '0;

   angle_word_type pending_angles [$];
   int  fails = 0;
   bit  no_idle = 1'b0;
   bit  hold_off = 1'b0;
   longint cycles = 0;

   tilt_complementary_filter_unit dut (.*);

   always #2 clock = ~clock;

   function automatic longint unsigned int_sqrt(longint unsigned n);
      longint unsigned root, bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
         if (n >= root + bitv) begin
            n -= root + bitv;
            root = (root >> 1) + bitv;
         end else begin
            root >>= 1;
         end
         bitv >>= 2;
      end
      return root;
   endfunction

   function automatic longint vector_angle(longint y, longint x);
      longint z, t, xs, ys;
      z = 0;
      if (x == 0 && y == 0) return 0;
      // pre-rotate a negative x into the right half plane
      if (x < 0) begin
         if (y >= 0) begin
            t = x; x = y; y = -t; z = Deg90Q16;
         end else begin
            t = x; x = -y; y = t; z = -Deg90Q16;
         end
      end
      for (int i = 0; i < tcf_pkg::CordicSteps && i < 24; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y < 0) begin
            x -= ys; y += xs; z -= atan_table[i];
         end else begin
            x += ys; y -= xs; z += atan_table[i];
         end
      end
      return z;
   endfunction

   function automatic logic signed [31:0] blend_angle(logic signed [31:0] prev,
         logic signed [15:0] rate, longint acc_angle);
      longint pred, a, sum;
      pred = longint'(prev) + ((longint'(rate) * longint'(dt_q24)) >>> 12);
      a = longint'(weight_q16);
      sum = (a * pred + (65536 - a) * acc_angle + 32768) >>> 16;
      if (sum > 64'sd2147483647) sum = 64'sd2147483647;
      if (sum < -64'sd2147483648) sum = -64'sd2147483648;
      return sum[31:0];
   endfunction

   function automatic logic signed [17:0] angle_out(logic signed [31:0] acc);
      longint v;
      v = longint'(acc) >>> 8;
      if (v > 131071) v = 131071;
      if (v < -131072) v = -131072;
      return v[17:0];
   endfunction

   // advance the predictor by one sample tick
   function automatic angle_word_type predict_angles(tick_row_type r);
      angle_word_type w;
      longint ax, ay, az, roll_acc, pitch_acc;
      longint unsigned mag;
      if (r.accel_fresh) begin
         hold_ax = r.accel_x; hold_ay = r.accel_y; hold_az = r.accel_z;
      end
      if (r.gyro_fresh) begin
         hold_rx = r.rate_x; hold_ry = r.rate_y;
      end
      ax = hold_ax; ay = hold_ay; az = hold_az;
      roll_acc = vector_angle(ay * 256, az * 256);
      mag = int_sqrt(longint'(ay * ay + az * az) << 16);
      pitch_acc = vector_angle(-ax * 256, longint'(mag));
      roll_q16 = blend_angle(roll_q16, hold_rx, roll_acc);
      pitch_q16 = blend_angle(pitch_q16, hold_ry, pitch_acc);
      w.roll = angle_out(roll_q16);
      w.pitch = angle_out(pitch_q16);
      return w;
   endfunction

   // watch both channels; check results first, then queue new predictions
   always @(posedge clock) begin
      tick_row_type r;
      angle_word_type w, e;
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (pending_angles.size() == 0) begin
               $display("%0t: unexpected result word roll=%0d pitch=%0d", $time,
                        rsp_roll_angle, rsp_pitch_angle);
               fails++;
            end else begin
               e = pending_angles.pop_front();
               if (rsp_roll_angle !== e.roll) begin
                  $display("%0t: roll expected %0d actual %0d", $time, e.roll, rsp_roll_angle);
                  fails++;
               end
               if (rsp_pitch_angle !== e.pitch) begin
                  $display("%0t: pitch expected %0d actual %0d", $time, e.pitch,
                           rsp_pitch_angle);
                  fails++;
               end
            end
         end
         if (req_valid && req_ready) begin
            r.accel_fresh = req_accel_fresh;
            r.accel_x = req_accel_x; r.accel_y = req_accel_y; r.accel_z = req_accel_z;
            r.gyro_fresh = req_gyro_fresh;
            r.rate_x = req_rate_x; r.rate_y = req_rate_y;
            w = predict_angles(r);
            if (cur_typed) begin
               w.roll = cur_roll;
               w.pitch = cur_pitch;
            end
            pending_angles.push_back(w);
         end
      end
   end

   // receiver: random stalls, one long hold-off on request
   initial begin
      int gap;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_off) begin
            rsp_ready <= 1'b0;
            repeat (400) @(posedge clock);
            hold_off = 1'b0;
         end
         gap = no_idle ? 0 : $urandom_range(0, GapMax);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
      end
   end

   task automatic drain_wait();
      while (pending_angles.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_regs(longint unsigned blend, longint unsigned dt);
      drain_wait();
      csr_write <= 1'b1;
      csr_index <= tcf_pkg::REG_BLEND_WEIGHT;
      csr_data <= 24'(blend);
      @(posedge clock);
      csr_index <= tcf_pkg::REG_TICK_SECONDS;
      csr_data <= 24'(dt);
      @(posedge clock);
      csr_write <= 1'b0;
      weight_q16 = blend & 16'hFFFF;
      dt_q24 = dt & 24'hFFFFFF;
   endtask

   // offer one word; valid stays high straight into the next word when there is no gap
   task automatic send_tick(tick_row_type r);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, GapMax);
      if (gap > 0 && req_valid) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end else if (gap > 0) begin
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_accel_fresh <= r.accel_fresh;
      req_accel_x <= r.accel_x; req_accel_y <= r.accel_y; req_accel_z <= r.accel_z;
      req_gyro_fresh <= r.gyro_fresh;
      req_rate_x <= r.rate_x; req_rate_y <= r.rate_y;
      cur_typed <= r.typed; cur_roll <= r.roll; cur_pitch <= r.pitch;
      do @(posedge clock); while (!(req_valid && req_ready));
   endtask

   function automatic tick_row_type random_tick();
      tick_row_type r;
      r.typed = 1'b0; r.roll = '0; r.pitch = '0;
      r.accel_fresh = $urandom_range(0, 1);
      r.gyro_fresh = $urandom_range(0, 1);
      if ($urandom_range(0, 3) != 0) begin
         // plausible sensor values around one g and modest rates
         r.accel_x = 16'($urandom_range(0, 8192)) - 16'sd4096;
         r.accel_y = 16'($urandom_range(0, 8192)) - 16'sd4096;
         r.accel_z = 16'($urandom_range(0, 8192)) - 16'sd4096;
         r.rate_x = 16'($urandom_range(0, 4000)) - 16'sd2000;
         r.rate_y = 16'($urandom_range(0, 4000)) - 16'sd2000;
      end else begin
         r.accel_x = 16'($urandom); r.accel_y = 16'($urandom); r.accel_z = 16'($urandom);
         r.rate_x = 16'($urandom); r.rate_y = 16'($urandom);
      end
      return r;
   endfunction

   // directed table: fresh_a, ax, ay, az, fresh_g, rx, ry, typed, roll, pitch
   tick_row_type directed [16] = '{
      '{1'b0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0, 1'b1, 18'sd0, 18'sd0},
      '{1'b1, 16'sd0, 16'sd0, 16'sd0, 1'b1, 16'sd0, 16'sd0, 1'b1, 18'sd0, 18'sd0},
      '{1'b1, 16'sd0, 16'sd0, 16'sd4096, 1'b0, 16'sd0, 16'sd0, 1'b0, 18'sd0, 18'sd0},
      '{1'b1, 16'sd0, 16'sd0, -16'sd4096, 1'b0, 16'sd0, 16'sd0, 1'b0, 18'sd0, 18'sd0},
      '{1'b1, 16'sd0, -16'sd4096, -16'sd4096, 1'b0, 16'sd0, 16'sd0, 1'b0, 18'sd0, 18'sd0},
      '{1'b1, 16'sd0, 16'sd4096, -16'sd4096, 1'b0, 16'sd0, 16'sd0, 1'b0, 18'sd0, 18'sd0},
      '{1'b1, 16'sd4096, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0, 1'b0, 18'sd0, 18'sd0},
      '{1'b1, -16'sd4096, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0, 1'b0, 18'sd0, 18'sd0},
      '{1'b1, 16'sd32767, 16'sd32767, 16'sd32767, 1'b0, 16'sd0, 16'sd0, 1'b0, 18'sd0, 18'sd0},
      '{1'b1, -16'sd32768, -16'sd32768, -16'sd32768, 1'b0, 16'sd0, 16'sd0, 1'b0,
        18'sd0, 18'sd0},
      '{1'b1, 16'sd0, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0, 1'b0, 18'sd0, 18'sd0},
      '{1'b0, 16'sd1234, -16'sd999, 16'sd77, 1'b1, 16'sd32767, -16'sd32768, 1'b0,
        18'sd0, 18'sd0},
      '{1'b0, -16'sd1, -16'sd1, -16'sd1, 1'b0, 16'sd5, 16'sd5, 1'b0, 18'sd0, 18'sd0},
      '{1'b1, 16'sd100, 16'sd200, 16'sd4000, 1'b1, -16'sd32768, 16'sd32767, 1'b0,
        18'sd0, 18'sd0},
      '{1'b1, -16'sd2896, 16'sd2896, 16'sd0, 1'b1, 16'sd0, 16'sd0, 1'b0, 18'sd0, 18'sd0},
      '{1'b0, 16'sd0, 16'sd0, 16'sd0, 1'b1, 16'sd16, -16'sd16, 1'b0, 18'sd0, 18'sd0}
   };

   // register settings per random phase: {blend_weight, tick_seconds}
   longint unsigned phase_cfg [6][2] = '{
      '{0, 1}, '{65535, 16777215}, '{65535, 0}, '{0, 0}, '{32768, 167772}, '{64225, 167772}
   };

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed[i]) send_tick(directed[i]);
      for (int p = 0; p < 6; p++) begin
         if (p == 4) phase_cfg[p] = '{$urandom_range(0, 65535), $urandom_range(1, 16777215)};
         if (req_valid) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
         write_regs(phase_cfg[p][0], phase_cfg[p][1]);
         for (int n = 0; n < 135; n++) begin
            no_idle = (n % 100) < 20;
            // stall the receiver once while words keep coming
            if (p == 1 && n == 40) hold_off = 1'b1;
            send_tick(random_tick());
         end
      end
      req_valid <= 1'b0;
      drain_wait();
      if (fails == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule
`default_nettype wire

/* files.f */
design/tcf_pkg.sv
design/tcf_ctrl.sv
design/tcf_datapath.sv
design/tilt_complementary_filter_unit.sv
tb/sv/tb_top.sv
